@@ design/bsm_pkg.sv @@
// Shared constants and helpers for the block SAD mean unit.
package bsm_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int PIX_W   = 8;
	localparam int SIZE_W  = 12;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 9;
	localparam int LINE_W  = 12;
	localparam int SUM_W   = 16;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 2;

	localparam int WIDTH_RST  = 64;
	localparam int HEIGHT_RST = 64;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_BLOCK_MODE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// block modes
	localparam logic [MODE_W-1:0] MODE_4X4   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_8X8   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_16X16 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

	// log2 of the block side
	function automatic logic [2:0] side_log2(input logic [MODE_W-1:0] mode);
		logic [2:0] lg;
		case (mode)
			MODE_4X4:   lg = 3'd2;
			MODE_8X8:   lg = 3'd3;
			MODE_16X16: lg = 3'd4;
			default:    lg = 3'd2;
		endcase
		return lg;
	endfunction

endpackage

@@ design/bsm_ram.sv @@
// Generic single write, single read RAM with registered read data.
module bsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/block_sad_mean.sv @@
// Top level of the block SAD mean unit: position tracking, sums and result register.
//
// Usage:
//   pix channel: pixel_a / pixel_b pairs in raster order, one item per accepted
//   edge (pix_valid high, pix_stall low). res channel: one item per completed
//   block with block_mean, block_col, block_row and frame_done, taken when
//   res_valid is high and res_stall low.
//   cfg port: cfg_we writes cfg_data into register cfg_index (0 mode, 1 width,
//   2 height) at the clock edge; write only while the block is idle.
// Result path: a block result passes through the input stage, then the result
//   register; both hold while a result waits with res_stall high.
// Throughput: one pixel per cycle while pix_stall is low, set by the single
//   read-modify-write of the per-column sum RAM, which is read when a pixel is
//   accepted and written back from the input stage when that stage advances.
// Reset: position, line partial and valids clear, config goes to its defaults. A
//   clearing pass zeroes all MAX_WIDTH/4 column sum RAM entries (512 at default),
//   one entry per cycle; pix_stall stays high meanwhile, config is still taken.
// Receiver stall: while a result waits in the output register with res_stall
//   high, the input stage holds and pix_stall is raised.
module block_sad_mean
	import bsm_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CIDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic [PIX_W-1:0]     pixel_a,
	input  logic [PIX_W-1:0]     pixel_b,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [PIX_W-1:0]     block_mean,
	output logic [IDX_W-1:0]     block_col,
	output logic [IDX_W-1:0]     block_row,
	output logic                 frame_done
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int SW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = XW - 2;
	localparam int RW    = YW - 2;
	localparam int SLOTS = MAX_WIDTH / 4;
	localparam int AW    = $clog2(SLOTS);

	// configuration
	logic [MODE_W-1:0] block_mode_q;
	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;

	// position and line state
	logic [XW-1:0]     pixel_x_q;
	logic [YW-1:0]     pixel_y_q;
	logic [LINE_W-1:0] line_partial_q;

	// RAM clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// input stage
	logic              s1_valid_s1;
	logic              seg_end_s1;
	logic              emit_s1;
	logic              first_y_s1;
	logic [LINE_W-1:0] lp_s1;
	logic [CW-1:0]     col_s1;
	logic [RW-1:0]     row_s1;
	logic              last_blk_s1;
	logic [3:0]        shift_s1;
	logic              fwd_s1;
	logic [SUM_W-1:0]  fwd_data_s1;

	// result register
	logic             res_valid_q;
	logic [PIX_W-1:0] mean_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic             done_q;

	// handshake
	logic adv;
	logic accept;

	assign adv       = !(res_valid_q && res_stall);
	assign pix_stall = clr_busy_q || !adv;
	assign accept    = pix_valid && !pix_stall;

	// ---- pixel decode, ahead of the input stage ----
	logic [SW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic [2:0]        lg;
	logic [3:0]        mask4;
	logic [SW-1:0]     ncols;
	logic [HW-1:0]     nrows;
	logic [CW-1:0]     col;
	logic [RW-1:0]     row;
	logic [3:0]        xi;
	logic [3:0]        yi;
	logic              active;
	logic              seg_end;
	logic [PIX_W-1:0]  diff;
	logic [LINE_W-1:0] lp_next;
	logic              last_blk;

	always_comb begin
		// sizes limited to 1..MAX
		if (image_width_q == '0) begin
			w_eff = SW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = SW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height_q);
		end

		lg    = side_log2(block_mode_q);
		mask4 = 4'((5'd1 << lg) - 5'd1);
		ncols = w_eff >> lg;
		nrows = h_eff >> lg;
		col   = CW'(pixel_x_q >> lg);
		row   = RW'(pixel_y_q >> lg);
		xi    = pixel_x_q[3:0] & mask4;
		yi    = pixel_y_q[3:0] & mask4;

		// partial blocks at the right and bottom edges are dropped
		active = (block_mode_q != MODE_OFF) && (32'(col) < 32'(ncols))
			&& (32'(row) < 32'(nrows)) && (32'(col) < SLOTS);
		seg_end = (xi == mask4);

		diff = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
		if (xi == 4'd0) begin
			lp_next = LINE_W'(diff);
		end else begin
			lp_next = line_partial_q + LINE_W'(diff);
		end

		last_blk = (32'(col) == 32'(ncols) - 32'd1) && (32'(row) == 32'(nrows) - 32'd1);
	end

	// ---- column sum RAM ----
	logic             wr_s1;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;
	logic [SUM_W-1:0] ram_wdata;
	logic [SUM_W-1:0] ram_rdata;
	logic [SUM_W-1:0] base;
	logic [SUM_W-1:0] sum;

	assign wr_s1     = s1_valid_s1 && seg_end_s1 && adv;
	assign base      = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign sum       = first_y_s1 ? SUM_W'(lp_s1) : base + SUM_W'(lp_s1);
	assign ram_we    = clr_busy_q || wr_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : AW'(col_s1);
	assign ram_wdata = clr_busy_q ? '0 : sum;
	assign ram_raddr = AW'(col);

	bsm_ram #(
		.WIDTH(SUM_W),
		.DEPTH(SLOTS)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mode_q   <= MODE_4X4;
			image_width_q  <= SIZE_W'(WIDTH_RST);
			image_height_q <= SIZE_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_MODE:   block_mode_q   <= cfg_data[MODE_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- clearing pass ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// ---- raster position and line partial ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q      <= '0;
			pixel_y_q      <= '0;
			line_partial_q <= '0;
		end else if (accept) begin
			if (active) begin
				line_partial_q <= lp_next;
			end
			if (32'(pixel_x_q) + 32'd1 >= 32'(w_eff)) begin
				pixel_x_q <= '0;
				if (32'(pixel_y_q) + 32'd1 >= 32'(h_eff)) begin
					pixel_y_q <= '0;
				end else begin
					pixel_y_q <= pixel_y_q + YW'(1);
				end
			end else begin
				pixel_x_q <= pixel_x_q + XW'(1);
			end
		end
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (adv) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_end_s1  <= active && seg_end;
			emit_s1     <= active && seg_end && (yi == mask4);
			first_y_s1  <= (yi == 4'd0);
			lp_s1       <= lp_next;
			col_s1      <= col;
			row_s1      <= row;
			last_blk_s1 <= last_blk;
			shift_s1    <= {lg, 1'b0};
			// write-back landing on the address being read
			fwd_s1      <= wr_s1 && (ram_waddr == ram_raddr);
			fwd_data_s1 <= sum;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= s1_valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_s1 && emit_s1) begin
			mean_q <= PIX_W'(sum >> shift_s1);
			col_q  <= IDX_W'(32'(col_s1));
			row_q  <= IDX_W'(32'(row_s1));
			done_q <= last_blk_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign block_mean = mean_q;
	assign block_col  = col_q;
	assign block_row  = row_q;
	assign frame_done = done_q;

`ifndef SYNTH
	// nothing flows while the sum RAM is being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !res_valid_q)
		else $error("result while clearing");

	a_no_stage_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_valid_s1)
		else $error("input stage busy while clearing");

	// a result only appears out of a loaded input stage
	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_valid_s1))
		else $error("result without input stage");
`endif

endmodule

@@ tb/block_sad_mean_tb.sv @@
// Self-checking testbench for block_sad_mean: directed items, back-pressure, then random images vs a predictor.
`timescale 1ns / 1ps

module block_sad_mean_tb
	import bsm_pkg::*;
();

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 8;      // result path is two registers deep
	localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
	localparam int TOTAL_ITEMS    = 1150;   // items sent over the whole run
	localparam int FINAL_ITEMS    = 128;    // items of the last part, no idling
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SUM_SLOTS      = MAX_WIDTH_DEF / 4;
	localparam int PLAN_ROWS      = 34;

	// write to this index must be ignored by the block
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic             done;
	} block_res_t;

	typedef enum logic {ROW_CFG, ROW_PIX} plan_kind_t;

	typedef struct {
		plan_kind_t        kind;
		logic [CIDX_W-1:0] idx;
		logic [CFG_W-1:0]  data;
		logic [PIX_W-1:0]  a;
		logic [PIX_W-1:0]  b;
		bit                typed;
		block_res_t        want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               pix_valid;
	logic               pix_stall;
	logic [PIX_W-1:0]   pixel_a;
	logic [PIX_W-1:0]   pixel_b;
	logic               res_valid;
	logic               res_stall;
	logic [PIX_W-1:0]   block_mean;
	logic [IDX_W-1:0]   block_col;
	logic [IDX_W-1:0]   block_row;
	logic               frame_done;

	block_sad_mean dut (.*);

	// ------------------------------------------------------------------
	// Predictor state: registers, raster position, line segment sum and
	// the per-column block sums of the current block row.
	// ------------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [10:0]       sad_x;
	logic [10:0]       sad_y;
	logic [LINE_W-1:0] seg_sum;
	logic [SUM_W-1:0]  col_sums [SUM_SLOTS];

	block_res_t pending_blocks [$];   // expected block results, oldest first
	int         fail_count;
	int         sent_items;
	int         cycle_count;
	bit         gaps_on;              // random idle bursts on both sides
	bit         hold_off_req;         // asks the receiver for one long hold

	plan_row_t  directed_plan [PLAN_ROWS];

	// sizes are limited to 1..MAX on use
	function automatic int eff_size(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(v);
	endfunction

	function automatic void sad_reset();
		mode_q   = MODE_4X4;
		width_q  = SIZE_W'(WIDTH_RST);
		height_q = SIZE_W'(HEIGHT_RST);
		sad_x    = '0;
		sad_y    = '0;
		seg_sum  = '0;
		foreach (col_sums[i])
			col_sums[i] = '0;
	endfunction

	function automatic void cfg_apply(input logic [CIDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_BLOCK_MODE:   mode_q = data[MODE_W-1:0];
			REG_IMAGE_WIDTH:  width_q = data;
			REG_IMAGE_HEIGHT: height_q = data;
			default: ;
		endcase
	endfunction

	// One pixel pair through the block: update sums, maybe finish a block,
	// then advance the raster position (wrapping past a shrunk size too).
	task automatic sad_predict(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			output bit hit, output block_res_t res);
		int w, h, lg, side, ncols, nrows, col, row, xi, yi;
		logic [PIX_W-1:0] diff;
		logic [SUM_W-1:0] s;
		hit = 0;
		res = '0;
		w = eff_size(width_q);
		h = eff_size(height_q);
		if (mode_q != MODE_OFF) begin
			lg    = 2 + int'(mode_q);
			side  = 1 << lg;
			ncols = w >> lg;
			nrows = h >> lg;
			col   = int'(sad_x) >> lg;
			row   = int'(sad_y) >> lg;
			if (col < ncols && row < nrows && col < SUM_SLOTS) begin
				diff = (a > b) ? a - b : b - a;
				xi = int'(sad_x) & (side - 1);
				yi = int'(sad_y) & (side - 1);
				if (xi == 0)
					seg_sum = LINE_W'(diff);
				else
					seg_sum = seg_sum + LINE_W'(diff);
				if (xi == side - 1) begin
					if (yi == 0)
						s = SUM_W'(seg_sum);
					else
						s = col_sums[col] + SUM_W'(seg_sum);
					col_sums[col] = s;
					if (yi == side - 1) begin
						hit      = 1;
						res.mean = PIX_W'(s >> (2 * lg));
						res.col  = IDX_W'(col);
						res.row  = IDX_W'(row);
						res.done = (col == ncols - 1 && row == nrows - 1);
					end
				end
			end
		end
		if (int'(sad_x) + 1 >= w) begin
			sad_x = '0;
			sad_y = (int'(sad_y) + 1 >= h) ? '0 : sad_y + 1'b1;
		end else begin
			sad_x = sad_x + 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d block results still expected", $time,
				pending_blocks.size());
			$display("block_sad_mean test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver pacing: random stall bursts, plus one long hold-off on
	// request so the output register fills and pix_stall backs up.
	// ------------------------------------------------------------------
	initial begin : res_pacing
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 6) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted result against the oldest expectation.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : res_check
		block_res_t want;
		if (res_valid && !res_stall) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected block result, expected none, actual col %0d row %0d",
					$time, block_col, block_row);
				fail_count++;
			end else begin
				want = pending_blocks.pop_front();
				check_field("block_mean", want.mean, block_mean);
				check_field("block_col", want.col, block_col);
				check_field("block_row", want.row, block_row);
				check_field("frame_done", want.done, frame_done);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one item and wait for the edge that takes it. Valid stays high
	// afterward; it only drops at the start of an idle burst or in settle().
	task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input bit typed, input block_res_t typed_res);
		bit hit;
		block_res_t res;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_a   <= a;
		pixel_b   <= b;
		do @(posedge clk); while (pix_stall);
		sad_predict(a, b, hit, res);
		if (typed)
			pending_blocks.push_back(typed_res);
		else if (hit)
			pending_blocks.push_back(res);
		sent_items++;
	endtask

	task automatic send_random();
		send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)), 0, '0);
	endtask

	// Block goes idle: all results back, then a wait of SETTLE_CYCLES for items that
	// finish no block but may still sit in the pipeline.
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_apply(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase: new mode and size, then mostly the rest of the
	// current image, sometimes cut short so the next phase starts mid-image.
	task automatic run_phase();
		int sel, side, wblk, hblk, w, h, wc, hc, remain, n, style;
		logic [MODE_W-1:0] m;
		logic [PIX_W-1:0] a, b;
		sel = $urandom_range(0, 9);
		m = (sel < 5) ? MODE_4X4 : (sel < 7) ? MODE_8X8 : (sel < 9) ? MODE_16X16 : MODE_OFF;
		side = (m == MODE_OFF) ? 4 : (4 << m);
		wblk = (side == 16) ? 2 : (side == 8) ? 3 : 5;
		hblk = (side == 16) ? 1 : (side == 8) ? 2 : 3;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			w = side * $urandom_range(1, wblk);
			h = side * $urandom_range(1, hblk);
		end else if (sel < 9) begin
			// trailing partial blocks
			w = $urandom_range(4, 40);
			h = $urandom_range(4, 24);
		end else begin
			// zero, tiny or oversized sizes; zero and oversized ones are clamped by the block
			case ($urandom_range(0, 2))
				0: w = 0;
				1: w = $urandom_range(1, 3);
				default: w = 4095;
			endcase
			h = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : 4095;
		end
		settle();
		gaps_on = ($urandom_range(0, 3) != 0);
		write_reg(REG_BLOCK_MODE, CFG_W'(m));
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		if ($urandom_range(0, 4) == 0)
			write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
		wc = eff_size(width_q);
		hc = eff_size(height_q);
		remain = (int'(sad_x) < wc && int'(sad_y) < hc) ?
			(hc - int'(sad_y)) * wc - int'(sad_x) : 0;
		if (sel == 9 || remain == 0 || remain > 1200)
			n = $urandom_range(1, 40);
		else if ($urandom_range(0, 4) == 0)
			n = $urandom_range(1, remain);
		else
			n = remain;
		// keep the random part within its share of the run
		if (n > TOTAL_ITEMS - FINAL_ITEMS - sent_items)
			n = TOTAL_ITEMS - FINAL_ITEMS - sent_items;
		style = $urandom_range(0, 2);
		repeat (n) begin
			a = PIX_W'($urandom_range(0, 255));
			case (style)
				0: b = PIX_W'($urandom_range(0, 255));
				1: b = a ^ PIX_W'($urandom_range(0, 3));   // near-equal images
				default: b = ~a;                            // mirrored values, odd differences from 1 to 255
			endcase
			send_pixel(a, b, 0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Directed plan rows
	// ------------------------------------------------------------------
	function automatic plan_row_t cfg_row(input logic [CIDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		plan_row_t r;
		r = '{kind: ROW_CFG, idx: idx, data: data, a: '0, b: '0, typed: 0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t pix_row(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		plan_row_t r;
		r = '{kind: ROW_PIX, idx: '0, data: '0, a: a, b: b, typed: 0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t last_row(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input block_res_t want);
		plan_row_t r;
		r = '{kind: ROW_PIX, idx: '0, data: '0, a: a, b: b, typed: 1, want: want};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		block_res_t full_block;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		pix_valid <= 1'b0;
		pixel_a   <= '0;
		pixel_b   <= '0;
		fail_count   = 0;
		sent_items   = 0;
		cycle_count  = 0;
		gaps_on      = 1;
		hold_off_req = 0;
		sad_reset();

		// 4x4 image of full-scale differences in both directions: one block,
		// mean 255, last block of the frame
		full_block = '{mean: 8'd255, col: 9'd0, row: 9'd0, done: 1'b1};
		directed_plan = '{
			cfg_row(REG_BLOCK_MODE, CFG_W'(MODE_4X4)),
			cfg_row(REG_IMAGE_WIDTH, 12'd4),
			cfg_row(REG_IMAGE_HEIGHT, 12'd4),
			pix_row(8'd255, 8'd0), pix_row(8'd0, 8'd255),
			pix_row(8'd255, 8'd0), pix_row(8'd0, 8'd255),
			pix_row(8'd0, 8'd255), pix_row(8'd255, 8'd0),
			pix_row(8'd0, 8'd255), pix_row(8'd255, 8'd0),
			pix_row(8'd255, 8'd0), pix_row(8'd0, 8'd255),
			pix_row(8'd255, 8'd0), pix_row(8'd0, 8'd255),
			pix_row(8'd0, 8'd255), pix_row(8'd255, 8'd0),
			pix_row(8'd0, 8'd255), last_row(8'd255, 8'd0, full_block),
			// output off: pixels only move the position
			cfg_row(REG_BLOCK_MODE, CFG_W'(MODE_OFF)),
			pix_row(8'd17, 8'd200), pix_row(8'd255, 8'd255),
			pix_row(8'd0, 8'd0), pix_row(8'd128, 8'd127),
			// unused index is dropped
			cfg_row(REG_UNUSED, 12'hFFF),
			cfg_row(REG_BLOCK_MODE, CFG_W'(MODE_4X4)),
			// zero width acts as one pixel per line: no block fits
			cfg_row(REG_IMAGE_WIDTH, 12'd0),
			pix_row(8'd1, 8'd254), pix_row(8'd254, 8'd1), pix_row(8'd90, 8'd90),
			// oversized image, limited to the maximum
			cfg_row(REG_IMAGE_WIDTH, 12'hFFF),
			cfg_row(REG_IMAGE_HEIGHT, 12'hFFF),
			pix_row(8'd200, 8'd10), pix_row(8'd10, 8'd200)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_plan[i].idx, directed_plan[i].data);
			end else begin
				send_pixel(directed_plan[i].a, directed_plan[i].b,
					directed_plan[i].typed, directed_plan[i].want);
			end
		end

		// Back-pressure: 8x8 images in 4x4 blocks while the receiver holds
		// off for a long stretch; the sender keeps offering, apart from random idle bursts.
		settle();
		write_reg(REG_IMAGE_WIDTH, 12'd8);
		write_reg(REG_IMAGE_HEIGHT, 12'd8);
		hold_off_req = 1;
		while (!(sad_x == 0 && sad_y == 0))
			send_random();
		repeat (128) send_random();

		while (sent_items < TOTAL_ITEMS - FINAL_ITEMS)
			run_phase();

		// Last part, no idling: 16x8 images in 4x4 blocks, back to back.
		settle();
		gaps_on = 0;
		write_reg(REG_BLOCK_MODE, CFG_W'(MODE_4X4));
		write_reg(REG_IMAGE_WIDTH, 12'd16);
		write_reg(REG_IMAGE_HEIGHT, 12'd8);
		repeat (FINAL_ITEMS) send_random();

		settle();
		if (fail_count == 0)
			$display("block_sad_mean test passed");
		else
			$display("block_sad_mean test failed");
		$finish;
	end

endmodule
